@@ rtl/dpp_pkg.sv @@
// Shared types and constants of the depth pixel to posed point block.
`timescale 1ns / 1ps

package dpp_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 63;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROT_X       = 3'd0,
    REG_ROT_Y       = 3'd1,
    REG_ROT_Z       = 3'd2,
    REG_TRANSLATION = 3'd3,
    REG_PRINCIPAL   = 3'd4,
    REG_INV_FOCAL   = 3'd5,
    REG_DEPTH_SCALE = 3'd6,
    REG_COLOUR      = 3'd7
  } cfg_reg_e;

  // Register reset values: identity rotation, zero offsets, 1 mm depth units
  localparam logic [47:0] RotXRst       = 48'h0000_0000_4000;
  localparam logic [47:0] RotYRst       = 48'h0000_4000_0000;
  localparam logic [47:0] RotZRst       = 48'h4000_0000_0000;
  localparam logic [62:0] TranslationRst = 63'd0;
  localparam logic [31:0] PrincipalRst  = 32'd0;
  localparam logic [47:0] InvFocalRst   = 48'd0;
  localparam logic [23:0] DepthScaleRst = 24'd16777;
  localparam logic [24:0] ColourRst     = 25'h100_0000;

  // Payload of one input item
  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row_index;
    logic [15:0] depth_raw;
    logic [7:0]  pixel_red;
    logic [7:0]  pixel_green;
    logic [7:0]  pixel_blue;
  } pixel_t;

  // Payload of one result item
  typedef struct packed {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
    logic [7:0]         out_red;
    logic [7:0]         out_green;
    logic [7:0]         out_blue;
  } point_t;

endpackage

@@ rtl/dpp_stream_if.sv @@
// Valid/ready stream channel carrying one payload item per handshake.
`timescale 1ns / 1ps

interface dpp_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/depth_pixel_to_posed_point.sv @@
// Depth pixel back-projection and rigid pose transform, eight-stage pipeline.
// An accepted item passes through stage registers 0 to 7 in order; stage 7 is the output register.
// Throughput: one item per cycle; the eight register stages each stall only
// when full and blocked downstream, so bubbles are squeezed out.
// Items out of the image or with zero scaled depth are dropped, no result.
// Reset clears all stage valid bits and loads the register reset values.
`timescale 1ns / 1ps

module depth_pixel_to_posed_point
  import dpp_pkg::*;
#(
  parameter int unsigned IMAGE_DIM_LIMIT = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  dpp_stream_if.sink          pix_i,
  dpp_stream_if.source        pnt_o
);

  localparam int unsigned NumStg = 8;
  localparam logic [31:0] DimLim = 32'(IMAGE_DIM_LIMIT);
  localparam logic signed [37:0] SatMax = 38'sd8388607;
  localparam logic signed [37:0] SatMin = -38'sd8388608;

  // Configuration registers
  logic [47:0] rot_q [3];
  logic [62:0] trans_q;
  logic [31:0] pp_q;
  logic [47:0] ifoc_q;
  logic [23:0] dscale_q;
  logic [24:0] colour_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0] <= RotXRst;
      rot_q[1] <= RotYRst;
      rot_q[2] <= RotZRst;
      trans_q  <= TranslationRst;
      pp_q     <= PrincipalRst;
      ifoc_q   <= InvFocalRst;
      dscale_q <= DepthScaleRst;
      colour_q <= ColourRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ROT_X:       rot_q[0] <= cfg_wdata_i[47:0];
        REG_ROT_Y:       rot_q[1] <= cfg_wdata_i[47:0];
        REG_ROT_Z:       rot_q[2] <= cfg_wdata_i[47:0];
        REG_TRANSLATION: trans_q  <= cfg_wdata_i;
        REG_PRINCIPAL:   pp_q     <= cfg_wdata_i[31:0];
        REG_INV_FOCAL:   ifoc_q   <= cfg_wdata_i[47:0];
        REG_DEPTH_SCALE: dscale_q <= cfg_wdata_i[23:0];
        REG_COLOUR:      colour_q <= cfg_wdata_i[24:0];
        default:         ;
      endcase
    end
  end

  // Stage valid bits and per-stage load enables
  logic [NumStg-1:0] v_q;
  logic [NumStg-1:0] en;

  always_comb begin
    en[NumStg-1] = !v_q[NumStg-1] || pnt_o.ready;
    for (int k = NumStg - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign pix_i.ready = en[0];

  pixel_t pix;
  logic   in_range;

  assign pix      = pix_i.data;
  assign in_range = ({20'd0, pix.column} < DimLim) && ({20'd0, pix.row_index} < DimLim);

  // Stage registers
  logic [39:0]        zf_q;
  logic signed [16:0] du_q, dv_q;
  logic [23:0]        rgb_q [NumStg];
  logic [31:0]        z16_1_q, z16_2_q;
  logic [27:0]        z12_q [1:4];
  logic signed [41:0] txp_q, typ_q;
  logic signed [29:0] tx_q, ty_q;
  logic signed [62:0] xp_q, yp_q;
  logic signed [33:0] x12_q, y12_q;
  logic signed [49:0] prod_q [3][3];
  logic signed [51:0] acc_q [3];
  logic signed [23:0] pt_q [3];

  // Advance valid bits; drop out-of-image pixels and zero depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= pix_i.valid && in_range;
      if (en[1]) v_q[1] <= v_q[0] && (zf_q != 40'd0);
      for (int k = 2; k < NumStg; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 0: scale depth, offset pixel from the principal point
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      zf_q <= 40'(pix.depth_raw) * 40'(dscale_q);
      du_q <= $signed({1'b0, pix.column, 4'b0000}) - $signed({1'b0, pp_q[15:0]});
      dv_q <= $signed({1'b0, pix.row_index, 4'b0000}) - $signed({1'b0, pp_q[31:16]});
    end
  end

  // Pick colour at entry and carry it along with the item
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      rgb_q[0] <= colour_q[24] ? {pix.pixel_red, pix.pixel_green, pix.pixel_blue}
                               : colour_q[23:0];
    end
    for (int k = 1; k < NumStg; k++) begin
      if (en[k]) rgb_q[k] <= rgb_q[k-1];
    end
  end

  // Stage 1: round depth to two scales, multiply offsets by inverse focal
  logic [40:0] z16_sum, z12_sum;

  assign z16_sum = {1'b0, zf_q} + 41'd128;
  assign z12_sum = {1'b0, zf_q} + 41'd2048;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      z16_1_q  <= z16_sum[39:8];
      z12_q[1] <= z12_sum[39:12];
      txp_q    <= 42'(du_q) * 42'($signed({1'b0, ifoc_q[23:0]}));
      typ_q    <= 42'(dv_q) * 42'($signed({1'b0, ifoc_q[47:24]}));
    end
  end

  // Stage 2: round normalized ray direction
  logic signed [41:0] tx_sum, ty_sum;

  assign tx_sum = txp_q + 42'sd2048;
  assign ty_sum = typ_q + 42'sd2048;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      tx_q     <= tx_sum[41:12];
      ty_q     <= ty_sum[41:12];
      z16_2_q  <= z16_1_q;
      z12_q[2] <= z12_q[1];
    end
  end

  // Stage 3: scale ray by depth
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      xp_q     <= 63'(tx_q) * 63'($signed({1'b0, z16_2_q}));
      yp_q     <= 63'(ty_q) * 63'($signed({1'b0, z16_2_q}));
      z12_q[3] <= z12_q[2];
    end
  end

  // Stage 4: round camera-frame coordinates to 2^-12 m
  logic signed [62:0] x_sum, y_sum;

  assign x_sum = xp_q + 63'sd134217728;
  assign y_sum = yp_q + 63'sd134217728;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      x12_q    <= x_sum[61:28];
      y12_q    <= y_sum[61:28];
      z12_q[4] <= z12_q[3];
    end
  end

  // Stage 5: rotation products
  logic signed [33:0] vec [3];

  assign vec[0] = x12_q;
  assign vec[1] = y12_q;
  assign vec[2] = $signed({6'd0, z12_q[4]});

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= 50'($signed(rot_q[r][16*c +: 16])) * 50'(vec[c]);
        end
      end
    end
  end

  // Stage 6: sum products and add translation
  logic signed [51:0] acc_d [3];
  logic signed [20:0] tr [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      tr[r] = $signed(trans_q[21*r +: 21]);
      acc_d[r] = $signed({{2{prod_q[r][0][49]}}, prod_q[r][0]})
               + $signed({{2{prod_q[r][1][49]}}, prod_q[r][1]})
               + $signed({{2{prod_q[r][2][49]}}, prod_q[r][2]})
               + $signed({{17{tr[r][20]}}, tr[r], 14'd0});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      for (int r = 0; r < 3; r++) begin
        acc_q[r] <= acc_d[r];
      end
    end
  end

  // Stage 7: round to 2^-12 m and saturate into the output register
  logic signed [51:0] rnd_sum [3];
  logic signed [37:0] rnd [3];
  logic signed [23:0] pt_d [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rnd_sum[r] = acc_q[r] + 52'sd8192;
      rnd[r]     = rnd_sum[r][51:14];
      if (rnd[r] > SatMax) begin
        pt_d[r] = 24'sh7F_FFFF;
      end else if (rnd[r] < SatMin) begin
        pt_d[r] = -24'sh80_0000;
      end else begin
        pt_d[r] = rnd[r][23:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      for (int r = 0; r < 3; r++) begin
        pt_q[r] <= pt_d[r];
      end
    end
  end

  // Drive the result item
  point_t pnt;

  always_comb begin
    pnt.point_x   = pt_q[0];
    pnt.point_y   = pt_q[1];
    pnt.point_z   = pt_q[2];
    pnt.out_red   = rgb_q[NumStg-1][23:16];
    pnt.out_green = rgb_q[NumStg-1][15:8];
    pnt.out_blue  = rgb_q[NumStg-1][7:0];
  end

  assign pnt_o.valid = v_q[NumStg-1];
  assign pnt_o.data  = pnt;

endmodule
